>>> hdl/nrte_pkg.sv
package nrte_pkg;

    // default limits and register values
    localparam int MAX_SENTENCE_DEF = 128;
    localparam logic [4:0] HOUR_OFFSET_RST = 5'd8;

    // ascii codes used by the parser
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_UPPER_V = 8'h56;

    // header is "$GPRMC," at positions 0 to 6
    localparam int HEADER_LEN = 7;
    // time digits occupy positions 7 to 12
    localparam int TIME_LAST = 12;

    typedef enum logic [1:0] {
        OP_CHAR   = 2'd0,
        OP_END    = 2'd1,
        OP_REPORT = 2'd2
    } op_t;

    typedef struct packed {
        logic [6:0] hh;
        logic [6:0] mm;
        logic [6:0] ss;
    } time_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // expected header byte at a header position
    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CHAR_DOLLAR;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4D;
            3'd5:    ch = 8'h43;
            3'd6:    ch = CHAR_COMMA;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // uppercase hex digit decode
    function automatic hex_t hex_decode(input logic [7:0] ch);
        hex_t h;
        h.ok    = 1'b0;
        h.value = ch[3:0];
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            h.ok = 1'b1;
        end
        else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F)
        begin
            h.ok    = 1'b1;
            h.value = 4'(ch[3:0] + 4'd9);
        end
        return h;
    endfunction

    // modulo 24 for values below 192
    function automatic logic [4:0] mod24(input logic [7:0] x);
        logic [7:0] r;
        r = x;
        if (r >= 8'd96) r = 8'(r - 8'd96);
        if (r >= 8'd48) r = 8'(r - 8'd48);
        if (r >= 8'd24) r = 8'(r - 8'd24);
        return r[4:0];
    endfunction

endpackage

>>> hdl/nrte_in_if.sv
interface nrte_in_if
    import nrte_pkg::*;
    ();
    logic       valid;
    logic       ready;
    op_t        op;
    logic [7:0] character;

    modport source (output valid, output op, output character, input ready);
    modport sink (input valid, input op, input character, output ready);
endinterface

>>> hdl/nrte_out_if.sv
interface nrte_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;

    modport source (output valid, output hours, output minutes, output seconds, input ready);
    modport sink (input valid, input hours, input minutes, input seconds, output ready);
endinterface

>>> hdl/nrte_parser.sv
module nrte_parser
    import nrte_pkg::*;
#(
    parameter int MAX_SENTENCE = MAX_SENTENCE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  op_t        op,
    input  logic [7:0] character,
    output time_t      held_time
);

    localparam int IDX_W = $clog2(MAX_SENTENCE + 1);

    logic [IDX_W-1:0] char_index_reg, char_index_next;
    logic             bad_reg, bad_next;
    logic [7:0]       xor_reg, xor_next;
    logic [3:0]       field_reg, field_next;
    logic             star_reg, star_next;
    logic [1:0]       hex_cnt_reg, hex_cnt_next;
    logic [7:0]       sum_reg, sum_next;
    time_t            cand_reg, cand_next;
    logic             fstart_reg, fstart_next;
    time_t            held_reg, held_next;

    hex_t             hex;
    logic [2:0]       digit_pos;
    logic [3:0]       digit;
    logic [6:0]       part;
    logic [6:0]       part_new;
    logic             is_digit;

    // decode helpers for the current character
    always_comb
    begin
        hex       = hex_decode(character);
        is_digit  = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
        digit     = character[3:0];
        digit_pos = 3'(char_index_reg - IDX_W'(HEADER_LEN));
        case (digit_pos[2:1])
            2'd0:    part = cand_reg.hh;
            2'd1:    part = cand_reg.mm;
            default: part = cand_reg.ss;
        endcase
        if (digit_pos[0])
            part_new = 7'(part + {3'b000, digit});
        else
            part_new = 7'({3'b000, digit, 3'b000} + {5'b00000, digit, 1'b0});
    end

    // next state for one item
    always_comb
    begin
        char_index_next = char_index_reg;
        bad_next        = bad_reg;
        xor_next        = xor_reg;
        field_next      = field_reg;
        star_next       = star_reg;
        hex_cnt_next    = hex_cnt_reg;
        sum_next        = sum_reg;
        cand_next       = cand_reg;
        fstart_next     = fstart_reg;
        held_next       = held_reg;
        case (op)
            OP_CHAR:
            begin
                if (char_index_reg >= IDX_W'(MAX_SENTENCE))
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    char_index_next = IDX_W'(char_index_reg + 1'b1);
                    if (char_index_reg < IDX_W'(HEADER_LEN))
                    begin
                        // fixed header, xor starts after the dollar
                        if (character != header_char(char_index_reg[2:0]))
                            bad_next = 1'b1;
                        if (char_index_reg != '0)
                            xor_next = xor_reg ^ character;
                        if (char_index_reg == IDX_W'(HEADER_LEN - 1))
                            field_next = 4'd1;
                    end
                    else if (star_reg)
                    begin
                        // checksum digits, exactly two
                        if (hex_cnt_reg >= 2'd2 || !hex.ok)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            sum_next     = {sum_reg[3:0], hex.value};
                            hex_cnt_next = 2'(hex_cnt_reg + 1'b1);
                        end
                    end
                    else if (character == CHAR_STAR)
                    begin
                        star_next = 1'b1;
                        if (char_index_reg <= IDX_W'(TIME_LAST))
                            bad_next = 1'b1;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ character;
                        if (char_index_reg <= IDX_W'(TIME_LAST))
                        begin
                            // hhmmss digits
                            if (!is_digit)
                                bad_next = 1'b1;
                            else
                            begin
                                case (digit_pos[2:1])
                                    2'd0:    cand_next.hh = part_new;
                                    2'd1:    cand_next.mm = part_new;
                                    default: cand_next.ss = part_new;
                                endcase
                            end
                        end
                        else if (character == CHAR_COMMA)
                        begin
                            if (field_reg != 4'd15)
                                field_next = 4'(field_reg + 1'b1);
                            fstart_next = 1'b1;
                        end
                        else
                        begin
                            // void status rejects
                            if (field_reg == 4'd2 && fstart_reg && character == CHAR_UPPER_V)
                                bad_next = 1'b1;
                            fstart_next = 1'b0;
                        end
                    end
                end
            end
            OP_END:
            begin
                if (!bad_reg && star_reg && hex_cnt_reg == 2'd2 && sum_reg == xor_reg)
                    held_next = cand_reg;
                char_index_next = '0;
                bad_next        = 1'b0;
                xor_next        = '0;
                field_next      = '0;
                star_next       = 1'b0;
                hex_cnt_next    = '0;
                sum_next        = '0;
                cand_next       = '0;
                fstart_next     = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_index_reg <= '0;
            bad_reg        <= 1'b0;
            xor_reg        <= '0;
            field_reg      <= '0;
            star_reg       <= 1'b0;
            hex_cnt_reg    <= '0;
            sum_reg        <= '0;
            cand_reg       <= '0;
            fstart_reg     <= 1'b0;
            held_reg       <= '0;
        end
        else if (step_en)
        begin
            char_index_reg <= char_index_next;
            bad_reg        <= bad_next;
            xor_reg        <= xor_next;
            field_reg      <= field_next;
            star_reg       <= star_next;
            hex_cnt_reg    <= hex_cnt_next;
            sum_reg        <= sum_next;
            cand_reg       <= cand_next;
            fstart_reg     <= fstart_next;
            held_reg       <= held_next;
        end
    end

    assign held_time = held_reg;

endmodule

>>> hdl/nrte_report.sv
module nrte_report
    import nrte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  time_t      held_time,
    input  logic [4:0] hour_offset,
    output logic       free,
    nrte_out_if.source report
);

    logic       valid_reg;
    logic [4:0] hours_reg;
    logic [6:0] minutes_reg;
    logic [6:0] seconds_reg;
    logic [4:0] hours_next;

    // hour with offset, reduced modulo 24
    assign hours_next = mod24(8'({1'b0, held_time.hh} + {3'b000, hour_offset}));
    assign free       = !valid_reg || report.ready;

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            hours_reg   <= hours_next;
            minutes_reg <= held_time.mm;
            seconds_reg <= held_time.ss;
        end
    end

    assign report.valid   = valid_reg;
    assign report.hours   = hours_reg;
    assign report.minutes = minutes_reg;
    assign report.seconds = seconds_reg;

endmodule

>>> hdl/nmea_rmc_time_extractor_top.sv
// NMEA RMC time extractor: sentence characters, end marks and report requests enter on
// the sentence channel, one item per clock cycle; each item is held in an input register
// and then processed by the parser in a single pass, so a report passes through the input
// register and then the report output register before it appears on the report channel.
// The only stall comes from the report output register: while an earlier report waits to
// be taken, a following report holds the input register, and no other item is accepted
// until that report moves on to the output register. Reports give
// the time of the last sentence that passed header, time, status and checksum checks,
// with the hour advanced by hour_offset modulo 24 (reset value 8, so 08:00:00 before any
// sentence is accepted). Write hour_offset through wr_en and wr_data only while idle.
module nmea_rmc_time_extractor_top
    import nrte_pkg::*;
#(
    parameter int MAX_SENTENCE = MAX_SENTENCE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [4:0] wr_data,
    nrte_in_if.sink    sentence,
    nrte_out_if.source report
);

    logic       stage_valid_reg;
    op_t        stage_op_reg;
    logic [7:0] stage_char_reg;
    logic [4:0] hour_offset_reg;
    logic       out_free;
    logic       advance;
    time_t      held_time;

    // input stage moves on unless a report is blocked by a full output
    assign advance        = stage_valid_reg && (stage_op_reg != OP_REPORT || out_free);
    assign sentence.ready = !stage_valid_reg || advance;

    // hour offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hour_offset_reg <= HOUR_OFFSET_RST;
        else if (wr_en)
            hour_offset_reg <= wr_data;
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (sentence.ready)
            stage_valid_reg <= sentence.valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (sentence.valid && sentence.ready)
        begin
            stage_op_reg   <= sentence.op;
            stage_char_reg <= sentence.character;
        end
    end

    nrte_parser #(
        .MAX_SENTENCE (MAX_SENTENCE)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .op        (stage_op_reg),
        .character (stage_char_reg),
        .held_time (held_time)
    );

    nrte_report u_report (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && stage_op_reg == OP_REPORT),
        .held_time   (held_time),
        .hour_offset (hour_offset_reg),
        .free        (out_free),
        .report      (report)
    );

endmodule
